[hw/rtl/cmms_pkg.sv]
`default_nettype none
package cmms_pkg;

    localparam int MAX_DIM      = 128;
    localparam int MAX_CHANNELS = 4;
    localparam int MEAN_DEPTH   = 65536;

    localparam int DIM_W   = $clog2(MAX_DIM + 1);
    localparam int POS_W   = $clog2(MAX_DIM);
    localparam int CH_W    = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1;
    localparam int NCH_W   = $clog2(MAX_CHANNELS + 1);
    localparam int MADDR_W = $clog2(MEAN_DEPTH);
    localparam int ROWS_W  = CH_W + DIM_W;
    localparam int LIN_W   = ROWS_W + DIM_W;

    localparam int OP_W       = 2;
    localparam int ADDR_W     = 16;
    localparam int MEAN_W     = 17;
    localparam int PIX_W      = 8;
    localparam int OFF_W      = 7;
    localparam int VALUE_W    = 42;
    localparam int INDEX_W    = 16;
    localparam int CHANS_W    = 3;
    localparam int SIZE_W     = 8;
    localparam int SCALE_W    = 24;
    localparam int MODE_W     = 2;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 24;

    localparam int FRAC_SHIFT = 8;
    localparam int DIFF_W     = PIX_W + FRAC_SHIFT + 2;
    localparam int PROD_W     = DIFF_W + SCALE_W + 1;

    localparam logic [OP_W-1:0] OP_LOAD  = 2'd0;
    localparam logic [OP_W-1:0] OP_START = 2'd1;
    localparam logic [OP_W-1:0] OP_PIXEL = 2'd2;

    localparam logic [MODE_W-1:0] MODE_CHAN = 2'd1;
    localparam logic [MODE_W-1:0] MODE_POS  = 2'd2;

    localparam logic [CFG_IDX_W-1:0] REG_CHANNELS    = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_SRC_HEIGHT  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_SRC_WIDTH   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_CROP_SIDE   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_SCALE       = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_MEAN_MODE   = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_RANDOM_CROP = 3'd6;

    typedef enum logic [1:0] {
        SEL_NONE,
        SEL_CHAN,
        SEL_POS
    } t_mean_sel;

    typedef struct packed {
        logic [CHANS_W-1:0] channels;
        logic [SIZE_W-1:0]  src_height;
        logic [SIZE_W-1:0]  src_width;
        logic [SIZE_W-1:0]  crop_side;
        logic [SCALE_W-1:0] scale;
        logic [MODE_W-1:0]  mean_mode;
        logic               random_crop;
    } t_cfg;

    typedef struct packed {
        logic [NCH_W-1:0] nc;
        logic [DIM_W-1:0] h;
        logic [DIM_W-1:0] w;
        logic [DIM_W-1:0] ch;
        logic [DIM_W-1:0] cw;
        logic             crop_on;
    } t_geom;

    typedef struct packed {
        logic                     is_load;
        logic                     wr_ok;
        logic [MADDR_W-1:0]       addr;
        logic signed [MEAN_W-1:0] wdata;
        logic [PIX_W-1:0]         pixel;
        logic [CH_W-1:0]          chan;
        logic [POS_W-1:0]         row;
        logic [POS_W-1:0]         col;
        logic [POS_W-1:0]         oh;
        logic [POS_W-1:0]         ow;
        logic                     last;
        t_mean_sel                sel;
    } t_s1;

    typedef struct packed {
        logic                     is_load;
        logic                     mem_en;
        logic [MADDR_W-1:0]       mem_addr;
        logic signed [MEAN_W-1:0] wdata;
        logic [PIX_W-1:0]         pixel;
        logic [INDEX_W-1:0]       out_index;
        logic                     last;
    } t_s3;

    typedef struct packed {
        logic [PIX_W-1:0]   pixel;
        logic               use_mean;
        logic [INDEX_W-1:0] out_index;
        logic               last;
    } t_s4;

    function automatic t_geom cmms_geom(t_cfg cfg);
        t_geom g;
        int    s;
        if (cfg.channels == '0) begin
            g.nc = NCH_W'(1);
        end else if (int'(cfg.channels) > MAX_CHANNELS) begin
            g.nc = NCH_W'(MAX_CHANNELS);
        end else begin
            g.nc = NCH_W'(cfg.channels);
        end
        if (cfg.src_height == '0) begin
            g.h = DIM_W'(1);
        end else if (int'(cfg.src_height) > MAX_DIM) begin
            g.h = DIM_W'(MAX_DIM);
        end else begin
            g.h = DIM_W'(cfg.src_height);
        end
        if (cfg.src_width == '0) begin
            g.w = DIM_W'(1);
        end else if (int'(cfg.src_width) > MAX_DIM) begin
            g.w = DIM_W'(MAX_DIM);
        end else begin
            g.w = DIM_W'(cfg.src_width);
        end
        s = int'(cfg.crop_side);
        if (s > int'(g.h)) begin
            s = int'(g.h);
        end
        if (s > int'(g.w)) begin
            s = int'(g.w);
        end
        g.crop_on = (cfg.crop_side != '0);
        g.ch = g.crop_on ? DIM_W'(s) : g.h;
        g.cw = g.crop_on ? DIM_W'(s) : g.w;
        return g;
    endfunction

endpackage
`default_nettype wire

[hw/rtl/cmms_raster.sv]
`default_nettype none
module cmms_raster import cmms_pkg::*; (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  t_cfg                     i_cfg,
    input  t_geom                    i_geom,
    input  logic                     i_accept,
    input  logic [OP_W-1:0]          i_op,
    input  logic [ADDR_W-1:0]        i_address,
    input  logic signed [MEAN_W-1:0] i_mean_entry,
    input  logic [PIX_W-1:0]         i_pixel,
    input  logic [OFF_W-1:0]         i_row_offset,
    input  logic [OFF_W-1:0]         i_col_offset,
    input  logic                     i_mirror,
    input  logic                     i_en_next,
    output logic                     o_en,
    output logic                     o_valid,
    output t_s1                      o_s1
);

    logic [CH_W-1:0]  r_chan;
    logic [POS_W-1:0] r_row;
    logic [POS_W-1:0] r_col;
    logic [POS_W-1:0] r_row_start;
    logic [POS_W-1:0] r_col_start;
    logic             r_mirror;
    logic             r_v1;
    t_s1              r_s1;

    logic [CH_W-1:0]  n_chan;
    logic [POS_W-1:0] n_row;
    logic [POS_W-1:0] n_col;
    logic [POS_W-1:0] n_row_start;
    logic [POS_W-1:0] n_col_start;
    t_s1              n_s1;

    logic             w_is_load;
    logic             w_is_start;
    logic             w_is_pixel;
    logic [DIM_W:0]   w_row_end;
    logic [DIM_W:0]   w_col_end;
    logic             w_in_win;
    logic [POS_W-1:0] w_ow_raw;
    logic [DIM_W-1:0] w_col_inc;
    logic [DIM_W-1:0] w_row_inc;
    logic [NCH_W-1:0] w_chan_inc;
    logic [DIM_W-1:0] w_row_room;
    logic [DIM_W-1:0] w_col_room;

    always_comb begin
        w_is_load  = 1'b0;
        w_is_start = 1'b0;
        w_is_pixel = 1'b0;
        case (i_op)
            OP_LOAD:  w_is_load  = 1'b1;
            OP_START: w_is_start = 1'b1;
            OP_PIXEL: w_is_pixel = 1'b1;
            default: ;
        endcase
    end

    always_comb begin
        w_row_end = (DIM_W+1)'(r_row_start) + (DIM_W+1)'(i_geom.ch);
        w_col_end = (DIM_W+1)'(r_col_start) + (DIM_W+1)'(i_geom.cw);
        w_in_win  = (r_row >= r_row_start) && ((DIM_W+1)'(r_row) < w_row_end) &&
                    (r_col >= r_col_start) && ((DIM_W+1)'(r_col) < w_col_end);
        w_ow_raw  = r_col - r_col_start;

        n_s1.is_load = w_is_load;
        n_s1.wr_ok   = (int'(i_address) < MEAN_DEPTH);
        n_s1.addr    = MADDR_W'(i_address);
        n_s1.wdata   = i_mean_entry;
        n_s1.pixel   = i_pixel;
        n_s1.chan    = r_chan;
        n_s1.row     = r_row;
        n_s1.col     = r_col;
        n_s1.oh      = r_row - r_row_start;
        n_s1.ow      = r_mirror ?
                       POS_W'(i_geom.cw - DIM_W'(1) - DIM_W'(w_ow_raw)) : w_ow_raw;
        n_s1.last    = (NCH_W'(r_chan) + NCH_W'(1) == i_geom.nc) &&
                       ((DIM_W+1)'(r_row) + (DIM_W+1)'(1) == w_row_end) &&
                       ((DIM_W+1)'(r_col) + (DIM_W+1)'(1) == w_col_end);
        case (i_cfg.mean_mode)
            MODE_CHAN: n_s1.sel = SEL_CHAN;
            MODE_POS:  n_s1.sel = SEL_POS;
            default:   n_s1.sel = SEL_NONE;
        endcase
    end

    always_comb begin
        w_col_inc  = DIM_W'(r_col) + DIM_W'(1);
        w_row_inc  = DIM_W'(r_row) + DIM_W'(1);
        w_chan_inc = NCH_W'(r_chan) + NCH_W'(1);
        n_chan     = r_chan;
        n_row      = r_row;
        n_col      = POS_W'(w_col_inc);
        if (w_col_inc >= i_geom.w) begin
            n_col = '0;
            n_row = POS_W'(w_row_inc);
            if (w_row_inc >= i_geom.h) begin
                n_row  = '0;
                n_chan = (w_chan_inc >= i_geom.nc) ? '0 : CH_W'(w_chan_inc);
            end
        end
    end

    always_comb begin
        w_row_room = i_geom.h - i_geom.ch;
        w_col_room = i_geom.w - i_geom.cw;
        if (!i_geom.crop_on) begin
            n_row_start = '0;
            n_col_start = '0;
        end else if (i_cfg.random_crop) begin
            n_row_start = (int'(i_row_offset) > int'(w_row_room)) ?
                          POS_W'(w_row_room) : POS_W'(i_row_offset);
            n_col_start = (int'(i_col_offset) > int'(w_col_room)) ?
                          POS_W'(w_col_room) : POS_W'(i_col_offset);
        end else begin
            n_row_start = POS_W'(w_row_room >> 1);
            n_col_start = POS_W'(w_col_room >> 1);
        end
    end

    assign o_en    = !r_v1 || i_en_next;
    assign o_valid = r_v1;
    assign o_s1    = r_s1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_chan      <= '0;
            r_row       <= '0;
            r_col       <= '0;
            r_row_start <= '0;
            r_col_start <= '0;
            r_mirror    <= 1'b0;
            r_v1        <= 1'b0;
        end else begin
            if (i_accept && w_is_start) begin
                r_row_start <= n_row_start;
                r_col_start <= n_col_start;
                r_mirror    <= i_mirror;
                r_chan      <= '0;
                r_row       <= '0;
                r_col       <= '0;
            end else if (i_accept && w_is_pixel) begin
                r_chan <= n_chan;
                r_row  <= n_row;
                r_col  <= n_col;
            end
            if (o_en) begin
                r_v1 <= i_accept && (w_is_load || (w_is_pixel && w_in_win));
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_en) begin
            r_s1 <= n_s1;
        end
    end

endmodule
`default_nettype wire

[hw/rtl/cmms_index.sv]
`default_nettype none
module cmms_index import cmms_pkg::*; (
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  t_geom i_geom,
    input  logic  i_valid,
    input  t_s1   i_s1,
    input  logic  i_en_next,
    output logic  o_en,
    output logic  o_valid,
    output t_s3   o_s3
);

    typedef struct packed {
        logic                     is_load;
        logic                     wr_ok;
        logic [MADDR_W-1:0]       addr;
        logic signed [MEAN_W-1:0] wdata;
        logic [PIX_W-1:0]         pixel;
        logic [CH_W-1:0]          chan;
        logic [POS_W-1:0]         col;
        logic [POS_W-1:0]         ow;
        logic                     last;
        t_mean_sel                sel;
        logic [ROWS_W-1:0]        src_rows;
        logic [ROWS_W-1:0]        out_rows;
    } t_s2;

    logic             r_v2;
    logic             r_v3;
    t_s2              r_s2;
    t_s3              r_s3;
    t_s2              n_s2;
    t_s3              n_s3;
    logic             w_en2;
    logic             w_en3;
    logic [LIN_W-1:0] w_src_lin;
    logic [LIN_W-1:0] w_out_lin;

    assign w_en3   = !r_v3 || i_en_next;
    assign w_en2   = !r_v2 || w_en3;
    assign o_en    = w_en2;
    assign o_valid = r_v3;
    assign o_s3    = r_s3;

    always_comb begin
        n_s2.is_load  = i_s1.is_load;
        n_s2.wr_ok    = i_s1.wr_ok;
        n_s2.addr     = i_s1.addr;
        n_s2.wdata    = i_s1.wdata;
        n_s2.pixel    = i_s1.pixel;
        n_s2.chan     = i_s1.chan;
        n_s2.col      = i_s1.col;
        n_s2.ow       = i_s1.ow;
        n_s2.last     = i_s1.last;
        n_s2.sel      = i_s1.sel;
        n_s2.src_rows = ROWS_W'(i_s1.chan) * ROWS_W'(i_geom.h) + ROWS_W'(i_s1.row);
        n_s2.out_rows = ROWS_W'(i_s1.chan) * ROWS_W'(i_geom.ch) + ROWS_W'(i_s1.oh);
    end

    always_comb begin
        w_src_lin = LIN_W'(r_s2.src_rows) * LIN_W'(i_geom.w) + LIN_W'(r_s2.col);
        w_out_lin = LIN_W'(r_s2.out_rows) * LIN_W'(i_geom.cw) + LIN_W'(r_s2.ow);

        n_s3.is_load   = r_s2.is_load;
        n_s3.wdata     = r_s2.wdata;
        n_s3.pixel     = r_s2.pixel;
        n_s3.out_index = INDEX_W'(w_out_lin);
        n_s3.last      = r_s2.last;
        if (r_s2.is_load) begin
            n_s3.mem_en   = r_s2.wr_ok;
            n_s3.mem_addr = r_s2.addr;
        end else begin
            case (r_s2.sel)
                SEL_CHAN: begin
                    n_s3.mem_en   = 1'b1;
                    n_s3.mem_addr = MADDR_W'(r_s2.chan);
                end
                SEL_POS: begin
                    n_s3.mem_en   = (int'(w_src_lin) < MEAN_DEPTH);
                    n_s3.mem_addr = MADDR_W'(w_src_lin);
                end
                default: begin
                    n_s3.mem_en   = 1'b0;
                    n_s3.mem_addr = '0;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
        end else begin
            if (w_en2) begin
                r_v2 <= i_valid;
            end
            if (w_en3) begin
                r_v3 <= r_v2;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en2) begin
            r_s2 <= n_s2;
        end
        if (w_en3) begin
            r_s3 <= n_s3;
        end
    end

endmodule
`default_nettype wire

[hw/rtl/cmms_mean_mem.sv]
`default_nettype none
module cmms_mean_mem import cmms_pkg::*; (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_valid,
    input  t_s3                      i_s3,
    input  logic                     i_en_next,
    output logic                     o_en,
    output logic                     o_valid,
    output t_s4                      o_s4,
    output logic signed [MEAN_W-1:0] o_mean
);

    logic signed [MEAN_W-1:0] r_mean_store [MEAN_DEPTH];
    logic signed [MEAN_W-1:0] r_mean;
    logic                     r_v4;
    t_s4                      r_s4;
    t_s4                      n_s4;

    assign o_en    = !r_v4 || i_en_next;
    assign o_valid = r_v4;
    assign o_s4    = r_s4;
    assign o_mean  = r_mean;

    always_comb begin
        n_s4.pixel     = i_s3.pixel;
        n_s4.use_mean  = i_s3.mem_en;
        n_s4.out_index = i_s3.out_index;
        n_s4.last      = i_s3.last;
    end

    always_ff @(posedge i_clk) begin
        if (o_en && i_valid && i_s3.mem_en) begin
            if (i_s3.is_load) begin
                r_mean_store[i_s3.mem_addr] <= i_s3.wdata;
            end else begin
                r_mean <= r_mean_store[i_s3.mem_addr];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v4 <= 1'b0;
        end else if (o_en) begin
            r_v4 <= i_valid && !i_s3.is_load;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_en) begin
            r_s4 <= n_s4;
        end
    end

endmodule
`default_nettype wire

[hw/rtl/cmms_scale.sv]
`default_nettype none
module cmms_scale import cmms_pkg::*; (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic [SCALE_W-1:0]        i_scale,
    input  logic                      i_valid,
    input  t_s4                       i_s4,
    input  logic signed [MEAN_W-1:0]  i_mean,
    input  logic                      i_ready,
    output logic                      o_en,
    output logic                      o_valid,
    output logic signed [VALUE_W-1:0] o_value,
    output logic [INDEX_W-1:0]        o_index,
    output logic                      o_last
);

    localparam logic signed [PROD_W-1:0] ROUND_HALF = PROD_W'(1) << (FRAC_SHIFT - 1);

    logic                      r_v5;
    logic                      r_v6;
    logic signed [PROD_W-1:0]  r_prod;
    logic [INDEX_W-1:0]        r_index5;
    logic                      r_last5;
    logic signed [VALUE_W-1:0] r_value;
    logic [INDEX_W-1:0]        r_index;
    logic                      r_last;

    logic                      w_en5;
    logic                      w_en6;
    logic signed [DIFF_W-1:0]  w_pix_q8;
    logic signed [DIFF_W-1:0]  w_mean_ext;
    logic signed [DIFF_W-1:0]  w_diff;
    logic signed [SCALE_W:0]   w_scale_s;
    logic signed [PROD_W-1:0]  w_prod;
    logic signed [PROD_W-1:0]  w_round;

    assign w_en6   = !r_v6 || i_ready;
    assign w_en5   = !r_v5 || w_en6;
    assign o_en    = w_en5;
    assign o_valid = r_v6;
    assign o_value = r_value;
    assign o_index = r_index;
    assign o_last  = r_last;

    always_comb begin
        w_pix_q8   = $signed({{(DIFF_W-PIX_W-FRAC_SHIFT){1'b0}}, i_s4.pixel,
                              {FRAC_SHIFT{1'b0}}});
        w_mean_ext = i_s4.use_mean ? DIFF_W'(i_mean) : '0;
        w_diff     = w_pix_q8 - w_mean_ext;
        w_scale_s  = $signed({1'b0, i_scale});
        w_prod     = PROD_W'(w_diff) * PROD_W'(w_scale_s);
        w_round    = r_prod + ROUND_HALF;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v5 <= 1'b0;
            r_v6 <= 1'b0;
        end else begin
            if (w_en5) begin
                r_v5 <= i_valid;
            end
            if (w_en6) begin
                r_v6 <= r_v5;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en5) begin
            r_prod   <= w_prod;
            r_index5 <= i_s4.out_index;
            r_last5  <= i_s4.last;
        end
        if (w_en6) begin
            r_value <= VALUE_W'(w_round >>> FRAC_SHIFT);
            r_index <= r_index5;
            r_last  <= r_last5;
        end
    end

endmodule
`default_nettype wire

[hw/rtl/crop_mirror_mean_scale_pixel_core.sv]
// Crop, mirror, mean-subtract and scale of a streamed planar 8-bit image.
//
// Slave stream: tuser carries the operation (load mean entry, start image,
// source pixel); tdata carries the item fields. Master stream: one beat per
// pixel inside the crop window, tdata = scaled value and output index, tlast
// on the final pixel of the image. Config channel: index and data, always
// ready; the user must write it only while the block is idle; not enforced.
//
// Throughput: one beat per cycle on both streams while the master stream is
// not stalled. An accepted pixel passes the raster register, two index
// stages, the mean memory read, the multiply and the rounding output
// register. Mean loads write the memory at the same stage where pixels read
// it, so load and read order is kept with no interlock.
//
// Reset clears the counters, crop origin, mirror flag and all stage valid
// bits, sets the config registers to their defaults, and leaves the mean
// memory uncleared. When the receiver stalls, the pipeline fills its empty
// stages and then holds s_axis_tready low until the output beat is taken.
`default_nettype none
module crop_mirror_mean_scale_pixel_core import cmms_pkg::*; (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  s_axis_tvalid,
    output logic                  s_axis_tready,
    // [15:0] address, [32:16] mean_entry, [40:33] pixel, [47:41] row_offset,
    // [54:48] col_offset, [55] mirror
    input  logic [55:0]           s_axis_tdata,
    // [1:0] operation
    input  logic [OP_W-1:0]       s_axis_tuser,
    output logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    // [41:0] value, [57:42] out_index, [63:58] zero
    output logic [63:0]           m_axis_tdata,
    output logic                  m_axis_tlast,
    input  logic                  i_cfg_valid,
    output logic                  o_cfg_ready,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data
);

    t_cfg                      r_cfg;
    t_geom                     w_geom;
    logic                      w_accept;
    logic                      w_en1;
    logic                      w_en2;
    logic                      w_en4;
    logic                      w_en5;
    logic                      w_v1;
    logic                      w_v3;
    logic                      w_v4;
    t_s1                       w_s1;
    t_s3                       w_s3;
    t_s4                       w_s4;
    logic signed [MEAN_W-1:0]  w_mean;
    logic signed [VALUE_W-1:0] w_value;
    logic [INDEX_W-1:0]        w_index;

    assign w_geom        = cmms_geom(r_cfg);
    assign s_axis_tready = w_en1;
    assign w_accept      = s_axis_tvalid && s_axis_tready;
    assign o_cfg_ready   = 1'b1;
    assign m_axis_tdata  = {{(64-VALUE_W-INDEX_W){1'b0}}, w_index, w_value};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.channels    <= CHANS_W'(1);
            r_cfg.src_height  <= SIZE_W'(128);
            r_cfg.src_width   <= SIZE_W'(128);
            r_cfg.crop_side   <= '0;
            r_cfg.scale       <= SCALE_W'(65536);
            r_cfg.mean_mode   <= '0;
            r_cfg.random_crop <= 1'b0;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                REG_CHANNELS:    r_cfg.channels    <= CHANS_W'(i_cfg_data);
                REG_SRC_HEIGHT:  r_cfg.src_height  <= SIZE_W'(i_cfg_data);
                REG_SRC_WIDTH:   r_cfg.src_width   <= SIZE_W'(i_cfg_data);
                REG_CROP_SIDE:   r_cfg.crop_side   <= SIZE_W'(i_cfg_data);
                REG_SCALE:       r_cfg.scale       <= SCALE_W'(i_cfg_data);
                REG_MEAN_MODE:   r_cfg.mean_mode   <= MODE_W'(i_cfg_data);
                REG_RANDOM_CROP: r_cfg.random_crop <= i_cfg_data[0];
                default: ;
            endcase
        end
    end

    cmms_raster u_raster (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg        (r_cfg),
        .i_geom       (w_geom),
        .i_accept     (w_accept),
        .i_op         (s_axis_tuser),
        .i_address    (s_axis_tdata[15:0]),
        .i_mean_entry ($signed(s_axis_tdata[32:16])),
        .i_pixel      (s_axis_tdata[40:33]),
        .i_row_offset (s_axis_tdata[47:41]),
        .i_col_offset (s_axis_tdata[54:48]),
        .i_mirror     (s_axis_tdata[55]),
        .i_en_next    (w_en2),
        .o_en         (w_en1),
        .o_valid      (w_v1),
        .o_s1         (w_s1)
    );

    cmms_index u_index (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_geom    (w_geom),
        .i_valid   (w_v1),
        .i_s1      (w_s1),
        .i_en_next (w_en4),
        .o_en      (w_en2),
        .o_valid   (w_v3),
        .o_s3      (w_s3)
    );

    cmms_mean_mem u_mean_mem (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_valid   (w_v3),
        .i_s3      (w_s3),
        .i_en_next (w_en5),
        .o_en      (w_en4),
        .o_valid   (w_v4),
        .o_s4      (w_s4),
        .o_mean    (w_mean)
    );

    cmms_scale u_scale (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_scale (r_cfg.scale),
        .i_valid (w_v4),
        .i_s4    (w_s4),
        .i_mean  (w_mean),
        .i_ready (m_axis_tready),
        .o_en    (w_en5),
        .o_valid (m_axis_tvalid),
        .o_value (w_value),
        .o_index (w_index),
        .o_last  (m_axis_tlast)
    );

endmodule
`default_nettype wire

[hw/rtl/cmms_checker.sv]
`default_nettype none
module cmms_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        s_axis_tready,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [63:0] m_axis_tdata,
    input logic        m_axis_tlast
);

    a_out_hold_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
        else $error("output beat dropped while stalled");

    a_out_hold_data: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> $stable(m_axis_tdata) && $stable(m_axis_tlast))
        else $error("output beat changed while stalled");

    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !m_axis_tvalid)
        else $error("output valid after reset");

    a_stall_from_output: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !s_axis_tready |-> m_axis_tvalid && !m_axis_tready)
        else $error("input stalled without output backpressure");

endmodule

bind crop_mirror_mean_scale_pixel_core cmms_checker u_cmms_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast)
);
`default_nettype wire

[bench/tb_crop_mirror_mean_scale_pixel_core.sv]
module tb_crop_mirror_mean_scale_pixel_core;
    timeunit 1ns;
    timeprecision 1ps;
    import cmms_pkg::*;

    localparam logic [OP_W-1:0]   OP_IGNORED    = 2'd3;
    localparam logic [MODE_W-1:0] MODE_OFF      = 2'd0;
    localparam logic [MODE_W-1:0] MODE_SPARE    = 2'd3;
    localparam int                STALL_LIMIT   = 2000;
    localparam int                SETTLE_CYCLES = 16;
    localparam int                FRAME_CAP     = 300;
    localparam int                POS_TABLE_MAX = 320;
    localparam int                RANDOM_ITEMS  = 1830;

    typedef struct packed {
        logic [OP_W-1:0]          op;
        logic [ADDR_W-1:0]        addr;
        logic signed [MEAN_W-1:0] mean;
        logic [PIX_W-1:0]         pixel;
        logic [OFF_W-1:0]         row_off;
        logic [OFF_W-1:0]         col_off;
        logic                     mirror;
    } t_src_beat;

    typedef struct packed {
        logic [VALUE_W-1:0] value;
        logic [INDEX_W-1:0] out_index;
        logic               last;
    } t_pixel_out;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n = 1'b0;
    logic                  s_axis_tvalid = 1'b0;
    logic                  s_axis_tready;
    logic [55:0]           s_axis_tdata = '0;
    logic [OP_W-1:0]       s_axis_tuser = '0;
    logic                  m_axis_tvalid;
    logic                  m_axis_tready = 1'b0;
    logic [63:0]           m_axis_tdata;
    logic                  m_axis_tlast;
    logic                  i_cfg_valid = 1'b0;
    logic                  o_cfg_ready;
    logic [CFG_IDX_W-1:0]  i_cfg_index = '0;
    logic [CFG_DATA_W-1:0] i_cfg_data = '0;

    // register shadow
    logic [CHANS_W-1:0] cfg_channels = 3'd1;
    logic [SIZE_W-1:0]  cfg_height = 8'd128;
    logic [SIZE_W-1:0]  cfg_width = 8'd128;
    logic [SIZE_W-1:0]  cfg_crop = 8'd0;
    logic [SCALE_W-1:0] cfg_scale = 24'd65536;
    logic [MODE_W-1:0]  cfg_mode = MODE_OFF;
    logic               cfg_random = 1'b0;

    // raster and window state
    int cnt_chan = 0;
    int cnt_row = 0;
    int cnt_col = 0;
    int win_row = 0;
    int win_col = 0;
    bit flip = 1'b0;
    logic signed [MEAN_W-1:0] mean_tbl [int];

    t_src_beat  src_beats [$];
    t_pixel_out pixel_results [$];
    bit         mean_seen [0:MEAN_DEPTH-1];
    t_src_beat  cur_beat;

    int send_gap_pct = 0;
    int recv_stall_pct = 0;
    int send_gap = 0;
    int stall_left = 0;
    int idle_cycles = 0;
    int n_queued = 0;
    int n_loads = 0;
    int n_starts = 0;
    int n_pixels = 0;
    int n_ignored = 0;
    int n_checked = 0;
    int n_errors = 0;
    int n_settings = 0;

    crop_mirror_mean_scale_pixel_core dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .s_axis_tvalid(s_axis_tvalid),
        .s_axis_tready(s_axis_tready),
        .s_axis_tdata (s_axis_tdata),
        .s_axis_tuser (s_axis_tuser),
        .m_axis_tvalid(m_axis_tvalid),
        .m_axis_tready(m_axis_tready),
        .m_axis_tdata (m_axis_tdata),
        .m_axis_tlast (m_axis_tlast),
        .i_cfg_valid  (i_cfg_valid),
        .o_cfg_ready  (o_cfg_ready),
        .i_cfg_index  (i_cfg_index),
        .i_cfg_data   (i_cfg_data)
    );

    always #5 i_clk = ~i_clk;

    function automatic void window_dims(output int nc, output int h, output int w,
                                        output int ch, output int cw);
        nc = (cfg_channels == '0) ? 1 :
             (int'(cfg_channels) > MAX_CHANNELS ? MAX_CHANNELS : int'(cfg_channels));
        h  = (cfg_height == '0) ? 1 : (int'(cfg_height) > MAX_DIM ? MAX_DIM : int'(cfg_height));
        w  = (cfg_width == '0) ? 1 : (int'(cfg_width) > MAX_DIM ? MAX_DIM : int'(cfg_width));
        if (cfg_crop == '0) begin
            ch = h;
            cw = w;
        end else begin
            ch = int'(cfg_crop);
            if (ch > h) begin
                ch = h;
            end
            if (ch > w) begin
                ch = w;
            end
            cw = ch;
        end
    endfunction

    function automatic void set_reg(input logic [CFG_IDX_W-1:0] idx,
                                    input logic [CFG_DATA_W-1:0] val);
        case (idx)
            REG_CHANNELS:    cfg_channels = val[CHANS_W-1:0];
            REG_SRC_HEIGHT:  cfg_height = val[SIZE_W-1:0];
            REG_SRC_WIDTH:   cfg_width = val[SIZE_W-1:0];
            REG_CROP_SIDE:   cfg_crop = val[SIZE_W-1:0];
            REG_SCALE:       cfg_scale = val[SCALE_W-1:0];
            REG_MEAN_MODE:   cfg_mode = val[MODE_W-1:0];
            REG_RANDOM_CROP: cfg_random = val[0];
            default: ;
        endcase
    endfunction

    function automatic void advance_image_state(input t_src_beat b);
        int nc, h, w, ch, cw, oh, ow;
        longint mean, prod;
        t_pixel_out res;
        window_dims(nc, h, w, ch, cw);
        case (b.op)
            OP_LOAD: begin
                mean_tbl[int'(b.addr)] = b.mean;
            end
            OP_START: begin
                if (cfg_crop == '0) begin
                    win_row = 0;
                    win_col = 0;
                end else if (cfg_random) begin
                    win_row = (int'(b.row_off) > h - ch) ? h - ch : int'(b.row_off);
                    win_col = (int'(b.col_off) > w - cw) ? w - cw : int'(b.col_off);
                end else begin
                    win_row = (h - ch) / 2;
                    win_col = (w - cw) / 2;
                end
                flip = b.mirror;
                cnt_chan = 0;
                cnt_row = 0;
                cnt_col = 0;
            end
            OP_PIXEL: begin
                if (cnt_row >= win_row && cnt_row < win_row + ch &&
                    cnt_col >= win_col && cnt_col < win_col + cw) begin
                    oh = cnt_row - win_row;
                    ow = cnt_col - win_col;
                    if (flip) begin
                        ow = cw - 1 - ow;
                    end
                    mean = 0;
                    if (cfg_mode == MODE_CHAN) begin
                        mean = mean_tbl[cnt_chan];
                    end else if (cfg_mode == MODE_POS) begin
                        mean = mean_tbl[(cnt_chan * h + cnt_row) * w + cnt_col];
                    end
                    prod = (longint'(b.pixel) * 256 - mean) * longint'(cfg_scale) + 128;
                    res.value = VALUE_W'(prod >>> 8);
                    res.out_index = INDEX_W'((cnt_chan * ch + oh) * cw + ow);
                    res.last = (cnt_chan == nc - 1 && cnt_row == win_row + ch - 1 &&
                                cnt_col == win_col + cw - 1);
                    pixel_results = {pixel_results, res};
                end
                cnt_col++;
                if (cnt_col >= w) begin
                    cnt_col = 0;
                    cnt_row++;
                    if (cnt_row >= h) begin
                        cnt_row = 0;
                        cnt_chan++;
                        if (cnt_chan >= nc) begin
                            cnt_chan = 0;
                        end
                    end
                end
            end
            default: ;
        endcase
    endfunction

    function automatic void check_beat(input logic [63:0] data, input logic tlast);
        t_pixel_out want;
        logic [VALUE_W-1:0] got_value;
        logic [INDEX_W-1:0] got_index;
        got_value = data[VALUE_W-1:0];
        got_index = data[VALUE_W +: INDEX_W];
        n_checked++;
        if (pixel_results.size() == 0) begin
            $error("unexpected output beat: value %0d out_index %0d last %0b",
                   $signed(got_value), got_index, tlast);
            n_errors++;
            return;
        end
        want = pixel_results.pop_front();
        if (got_value !== want.value) begin
            $error("value: expected %0d, got %0d", $signed(want.value), $signed(got_value));
            n_errors++;
        end
        if (got_index !== want.out_index) begin
            $error("out_index: expected %0d, got %0d", want.out_index, got_index);
            n_errors++;
        end
        if (tlast !== want.last) begin
            $error("last: expected %0b, got %0b", want.last, tlast);
            n_errors++;
        end
    endfunction

    function automatic int pick_gap(input int pct);
        if ($urandom_range(99) >= pct) begin
            return 0;
        end
        if ($urandom_range(9) < 8) begin
            return $urandom_range(1, 3);
        end
        return $urandom_range(8, 40);
    endfunction

    function automatic int pick_pct();
        case ($urandom_range(3))
            0: return 0;
            1: return 10;
            2: return 30;
            default: return 60;
        endcase
    endfunction

    function automatic logic [MEAN_W-1:0] rand_mean();
        case ($urandom_range(9))
            0: return 17'h0FFFF;
            1: return 17'h10000;
            default: return MEAN_W'($urandom);
        endcase
    endfunction

    function automatic logic [PIX_W-1:0] rand_pixel();
        case ($urandom_range(7))
            0: return 8'd0;
            1: return 8'd255;
            default: return PIX_W'($urandom);
        endcase
    endfunction

    function automatic logic [SCALE_W-1:0] pick_scale();
        case ($urandom_range(5))
            0: return '0;
            1: return 24'hFFFFFF;
            2: return 24'h010000;
            3: return SCALE_W'($urandom_range(0, 1023));
            default: return SCALE_W'($urandom);
        endcase
    endfunction

    function automatic int pick_side();
        case ($urandom_range(19))
            0: return 0;
            1: return $urandom_range(129, 255);
            default: return $urandom_range(1, 8);
        endcase
    endfunction

    function automatic t_src_beat any_beat(input logic [OP_W-1:0] op);
        t_src_beat b;
        b.op = op;
        b.addr = ADDR_W'($urandom);
        b.mean = MEAN_W'($urandom);
        b.pixel = PIX_W'($urandom);
        b.row_off = OFF_W'($urandom);
        b.col_off = OFF_W'($urandom);
        b.mirror = 1'($urandom_range(1));
        return b;
    endfunction

    function automatic void push_load(input int addr, input logic [MEAN_W-1:0] mean);
        t_src_beat b;
        b = any_beat(OP_LOAD);
        b.addr = ADDR_W'(addr);
        b.mean = mean;
        mean_seen[addr] = 1'b1;
        src_beats = {src_beats, b};
        n_queued++;
    endfunction

    function automatic void push_start(input int row, input int col, input bit mir);
        t_src_beat b;
        b = any_beat(OP_START);
        b.row_off = OFF_W'(row);
        b.col_off = OFF_W'(col);
        b.mirror = mir;
        src_beats = {src_beats, b};
        n_queued++;
    endfunction

    function automatic void push_random_start();
        if ($urandom_range(1)) begin
            push_start($urandom_range(0, 8), $urandom_range(0, 8), 1'($urandom_range(1)));
        end else begin
            push_start($urandom_range(0, 127), $urandom_range(0, 127),
                       1'($urandom_range(1)));
        end
    endfunction

    function automatic void push_pixel(input logic [PIX_W-1:0] pix);
        t_src_beat b;
        b = any_beat(OP_PIXEL);
        b.pixel = pix;
        src_beats = {src_beats, b};
        n_queued++;
    endfunction

    function automatic void push_noise();
        case ($urandom_range(2))
            0: src_beats = {src_beats, any_beat(OP_IGNORED)};
            1: push_load($urandom_range(0, MEAN_DEPTH - 1), rand_mean());
            default: push_random_start();
        endcase
    endfunction

    task automatic wait_idle();
        do begin
            @(negedge i_clk);
        end while (src_beats.size() != 0 || s_axis_tvalid || pixel_results.size() != 0);
    endtask

    task automatic begin_config();
        wait_idle();
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input int val);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= CFG_DATA_W'(val);
        do begin
            @(posedge i_clk);
        end while (!o_cfg_ready);
        set_reg(idx, CFG_DATA_W'(val));
    endtask

    task automatic end_config();
        i_cfg_valid <= 1'b0;
        n_settings++;
        @(negedge i_clk);
    endtask

    task automatic run_random_setting(input bit force_pause);
        int nc, h, w, ch, cw, kind, frames, npix, pause_at, hv, wv;
        logic [MODE_W-1:0] mode;
        kind = $urandom_range(99);
        if (kind < 85) begin
            hv = pick_side();
            wv = pick_side();
        end else if (kind < 93) begin
            hv = $urandom_range(100, 255);
            wv = $urandom_range(1, 2);
        end else begin
            hv = $urandom_range(1, 2);
            wv = $urandom_range(100, 255);
        end
        begin_config();
        write_reg(REG_CHANNELS, ($urandom_range(9) < 7) ? $urandom_range(1, 4) :
                                                          $urandom_range(0, 7));
        write_reg(REG_SRC_HEIGHT, hv);
        write_reg(REG_SRC_WIDTH, wv);
        kind = $urandom_range(19);
        write_reg(REG_CROP_SIDE, (kind < 6) ? 0 :
                                 (kind < 17) ? $urandom_range(1, 8) : $urandom_range(0, 255));
        window_dims(nc, h, w, ch, cw);
        mode = MODE_W'($urandom_range(3));
        if (mode == MODE_POS && nc * h * w > POS_TABLE_MAX) begin
            mode = MODE_CHAN;
        end
        write_reg(REG_SCALE, int'(pick_scale()));
        write_reg(REG_MEAN_MODE, int'(mode));
        write_reg(REG_RANDOM_CROP, $urandom_range(1));
        end_config();
        send_gap_pct = pick_pct();
        recv_stall_pct = pick_pct();

        if (mode == MODE_POS) begin
            for (int p = 0; p < nc * h * w; p++) begin
                if (!mean_seen[p]) begin
                    push_load(p, rand_mean());
                end
            end
        end
        frames = $urandom_range(1, 3);
        for (int f = 0; f < frames; f++) begin
            // stale counters are only safe when no position table is read
            if (f != 0 || mode == MODE_POS || $urandom_range(3) != 0) begin
                push_random_start();
            end
            npix = (nc * h * w > FRAME_CAP) ? FRAME_CAP : nc * h * w;
            if ($urandom_range(9) == 0) begin
                npix = $urandom_range(1, npix);
            end
            if (npix > RANDOM_ITEMS - n_queued) begin
                npix = (RANDOM_ITEMS - n_queued > 0) ? RANDOM_ITEMS - n_queued : 1;
            end
            pause_at = (f == 0 && (force_pause || $urandom_range(3) == 0)) ? npix / 2 : -1;
            for (int i = 0; i < npix; i++) begin
                if (i == pause_at) begin
                    wait_idle();
                end
                if ($urandom_range(99) < 6) begin
                    push_noise();
                end
                push_pixel(rand_pixel());
            end
        end
    endtask

    // source driver
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            s_axis_tvalid <= 1'b0;
        end else begin
            if (s_axis_tvalid && s_axis_tready) begin
                advance_image_state(cur_beat);
                case (cur_beat.op)
                    OP_LOAD:  n_loads++;
                    OP_START: n_starts++;
                    OP_PIXEL: n_pixels++;
                    default:  n_ignored++;
                endcase
            end
            if (!s_axis_tvalid || s_axis_tready) begin
                if (send_gap > 0) begin
                    send_gap--;
                    s_axis_tvalid <= 1'b0;
                end else if (src_beats.size() != 0) begin
                    cur_beat = src_beats.pop_front();
                    s_axis_tdata <= {cur_beat.mirror, cur_beat.col_off, cur_beat.row_off,
                                     cur_beat.pixel, cur_beat.mean, cur_beat.addr};
                    s_axis_tuser <= cur_beat.op;
                    s_axis_tvalid <= 1'b1;
                    send_gap = pick_gap(send_gap_pct);
                end else begin
                    s_axis_tvalid <= 1'b0;
                end
            end
        end
    end

    // result monitor
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            m_axis_tready <= 1'b0;
            stall_left = 0;
        end else begin
            if (m_axis_tvalid && m_axis_tready) begin
                check_beat(m_axis_tdata, m_axis_tlast);
            end
            if (stall_left > 0) begin
                stall_left--;
                m_axis_tready <= 1'b0;
            end else begin
                m_axis_tready <= 1'b1;
                stall_left = pick_gap(recv_stall_pct);
            end
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
                (i_cfg_valid && o_cfg_ready)) begin
                idle_cycles = 0;
            end else begin
                idle_cycles++;
            end
            if (idle_cycles >= STALL_LIMIT) begin
                $display("simulation failed");
                $finish;
            end
        end
    end

    initial begin
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // reset settings, pixels before any start, then mean table loads
        push_pixel(8'd0);
        push_pixel(8'd255);
        push_pixel(rand_pixel());
        src_beats = {src_beats, any_beat(OP_IGNORED)};
        push_load(0, 17'h0FFFF);
        push_load(1, 17'h10000);
        push_load(2, rand_mean());
        push_load(3, rand_mean());
        push_load(16'hFFFF, rand_mean());

        // column counter left past the new width; oversized random offsets
        begin_config();
        write_reg(REG_CHANNELS, 2);
        write_reg(REG_SRC_HEIGHT, 3);
        write_reg(REG_SRC_WIDTH, 3);
        write_reg(REG_CROP_SIDE, 2);
        write_reg(REG_SCALE, 24'hFFFFFF);
        write_reg(REG_MEAN_MODE, MODE_CHAN);
        write_reg(REG_RANDOM_CROP, 1);
        end_config();
        push_pixel(8'd255);
        push_start(127, 127, 1'b1);
        push_pixel(8'd0);
        push_pixel(8'd255);
        repeat (4) push_pixel(rand_pixel());

        // clamped registers, crop larger than source, centred, unused mean mode
        begin_config();
        write_reg(REG_CHANNELS, 7);
        write_reg(REG_SRC_HEIGHT, 0);
        write_reg(REG_SRC_WIDTH, 3);
        write_reg(REG_CROP_SIDE, 200);
        write_reg(REG_SCALE, 0);
        write_reg(REG_MEAN_MODE, MODE_SPARE);
        write_reg(REG_RANDOM_CROP, 0);
        end_config();
        push_random_start();
        repeat (3) push_pixel(rand_pixel());

        // random crop with no crop side, per-position mean, full frame
        begin_config();
        write_reg(REG_CHANNELS, 0);
        write_reg(REG_SRC_HEIGHT, 2);
        write_reg(REG_SRC_WIDTH, 2);
        write_reg(REG_CROP_SIDE, 0);
        write_reg(REG_SCALE, 24'h010000);
        write_reg(REG_MEAN_MODE, MODE_POS);
        write_reg(REG_RANDOM_CROP, 1);
        end_config();
        push_start(5, 5, 1'b1);
        repeat (4) push_pixel(rand_pixel());

        n_queued = 0;
        while (n_queued < RANDOM_ITEMS) begin
            run_random_setting(n_queued == 0);
        end

        wait_idle();
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        if (pixel_results.size() != 0) begin
            $error("%0d expected output beats never arrived", pixel_results.size());
            n_errors++;
        end
        $display("Sent %0d loads, %0d starts, %0d pixels, %0d ignored beats over %0d settings.",
                 n_loads, n_starts, n_pixels, n_ignored, n_settings);
        $display("Checked %0d output beats, %0d mismatches.", n_checked, n_errors);
        if (n_errors == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule
